@@ hw/rtl/mcr_pkg.sv @@
// shared types, constants and helpers for the max complementary run core
package mcr_pkg;

  localparam int unsigned BaseW          = 2;
  localparam int unsigned RunW           = 5;
  localparam int unsigned RegBases       = 20;
  localparam int unsigned TargetW        = BaseW * RegBases;
  localparam int unsigned TargetLenDflt  = 20;
  localparam int unsigned TdataInW       = 8;
  localparam int unsigned TdataOutW      = 8;
  localparam logic [RunW-1:0] RunMax     = '1;

  // one processing step handed to the counter array
  typedef struct packed {
    logic             step;
    logic [BaseW-1:0] base;
    logic             last;
  } step_t;

  // codes complement when they differ only in the low bit
  function automatic logic complementary(input logic [BaseW-1:0] a,
                                         input logic [BaseW-1:0] b);
    logic [BaseW-1:0] x;
    x = a ^ b;
    return x == BaseW'(1);
  endfunction

endpackage

@@ hw/rtl/mcr_diag_array.sv @@
// per target position run counters and the running best
module mcr_diag_array #(
  parameter int unsigned TARGET_LEN = mcr_pkg::TargetLenDflt
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mcr_pkg::step_t              step_i,
  input  logic [mcr_pkg::TargetW-1:0] target_bases_i,
  output logic [mcr_pkg::RunW-1:0]    best_o
);
  import mcr_pkg::*;

  logic [RunW-1:0]       runs_q [TARGET_LEN];
  logic [RunW-1:0]       runs_d [TARGET_LEN];
  logic [TARGET_LEN-1:0] hit;
  logic [RunW-1:0]       best_q;
  logic [RunW-1:0]       best_d;

  for (genvar k = 0; k < TARGET_LEN; k++) begin : g_pos
    logic [BaseW-1:0] tgt;
    logic [RunW-1:0]  prev;
    logic             match;

    if (k < RegBases) begin : g_reg
      assign tgt = target_bases_i[BaseW*k +: BaseW];
    end else begin : g_zero
      assign tgt = '0;
    end

    if (k == 0) begin : g_first
      assign prev = '0;
    end else begin : g_chain
      assign prev = runs_q[k-1];
    end

    assign match     = complementary(tgt, step_i.base);
    assign runs_d[k] = !match ? '0 : (prev == RunMax) ? RunMax : prev + RunW'(1);
    // a new counter can pass the best by at most one
    assign hit[k]    = match && (prev == best_q);
  end

  assign best_d = (|hit && (best_q != RunMax)) ? best_q + RunW'(1) : best_q;
  assign best_o = best_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
      for (int i = 0; i < TARGET_LEN; i++) runs_q[i] <= '0;
    end else if (step_i.step) begin
      best_q <= step_i.last ? '0 : best_d;
      for (int i = 0; i < TARGET_LEN; i++) runs_q[i] <= step_i.last ? '0 : runs_d[i];
    end
  end

endmodule

@@ hw/rtl/max_complementary_run_core.sv @@
// top level of the max complementary run core: stream ports, target register, result register
//
// Streams a probe strand, one 2-bit base per request, against a target strand held in a
// 40-bit register (base k in bits 2k+1..2k, positions from 20 up read as code 0). Codes 0/1
// and 2/3 complement. Every target position keeps a run counter that follows its diagonal;
// on the base flagged by tlast the longest complementary run over all overlap alignments
// (overhangs included, saturating at 31) leaves on the master side and all counters clear,
// while the target is kept. Throughput is one base per clock, though a last base waits for
// a free result slot: all counters update in parallel from the input register, and the best
// only ever grows by one, so it follows from an equality check per position. The target may
// only be rewritten while no probe is in flight.
module max_complementary_run_core #(
  parameter int unsigned TARGET_LEN = mcr_pkg::TargetLenDflt
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [mcr_pkg::TargetW-1:0]   cfg_wdata_i,    // target_bases
  // probe stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [mcr_pkg::TdataInW-1:0]  s_axis_tdata_i, // [1:0] base, rest zero
  input  logic                          s_axis_tlast_i, // last_base
  // result stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [mcr_pkg::TdataOutW-1:0] m_axis_tdata_o  // [4:0] longest_run, rest zero
);
  import mcr_pkg::*;

  logic [TargetW-1:0] target_q;

  // input register
  logic               in_valid_q;
  logic [BaseW-1:0]   in_base_q;
  logic               in_last_q;

  // result register
  logic               out_valid_q;
  logic [RunW-1:0]    out_run_q;

  logic               out_free;
  logic               proc;
  step_t              step;
  logic [RunW-1:0]    best;

  // the result slot frees up in the cycle its content is taken
  assign out_free = !out_valid_q || m_axis_tready_i;
  // ordinary bases never wait; a last base waits for the result slot
  assign proc     = in_valid_q && (!in_last_q || out_free);

  assign s_axis_tready_o = !in_valid_q || proc;

  assign step.step = proc;
  assign step.base = in_base_q;
  assign step.last = in_last_q;

  mcr_diag_array #(
    .TARGET_LEN(TARGET_LEN)
  ) u_diag (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .target_bases_i(target_q),
    .best_o        (best)
  );

  // target register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_base_q <= s_axis_tdata_i[BaseW-1:0];
      in_last_q <= s_axis_tlast_i;
    end
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && in_last_q) begin
      out_run_q <= best;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = TdataOutW'(out_run_q);

  // a result appears only right after a last base was counted
  a_result_from_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(proc && in_last_q))
    else $error("result without a last base");

  // a pending result is never overwritten
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && in_last_q) |-> out_free)
    else $error("result register overwritten");

  // backpressure on the probe side only comes from a held item
  a_ready_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && in_last_q && out_valid_q && !m_axis_tready_i))
    else $error("input stalled without cause");

  // no run can exceed the target length
  a_run_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((TARGET_LEN >= 31) || (32'(out_run_q) <= TARGET_LEN)))
    else $error("run longer than target");

endmodule

@@ bench/testbench.sv @@
// testbench for max_complementary_run_core: probe streams checked against a run predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mcr_pkg::*;

  localparam int unsigned TARGET_LEN = TargetLenDflt;
  localparam int unsigned IdleLimit  = 3000;  // cycles with no request moving on either side
  localparam int unsigned HoldCycles = 500;   // long hold-off of the result sink
  localparam int unsigned DrainWait  = 6;     // extra wait once nothing is left in flight
  localparam int unsigned PhaseBases = 52;    // minimum of probe bases queued per target setting
  localparam int unsigned Phases     = 10;

  // one probe base as the driver offers it
  typedef struct packed {
    logic [BaseW-1:0] base;
    logic             last;
  } probe_base_t;

  logic                 clk_i;
  logic                 rst_ni    = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [TargetW-1:0]   cfg_wdata = '0;
  logic                 s_valid   = 1'b0;
  logic                 s_ready;
  logic [TdataInW-1:0]  s_data    = '0;   // [1:0] base, rest zero
  logic                 s_last    = 1'b0; // last_base
  logic                 m_valid;
  logic                 m_ready   = 1'b0;
  logic [TdataOutW-1:0] m_data;           // [4:0] longest_run, rest zero

  max_complementary_run_core #(
    .TARGET_LEN(TARGET_LEN)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)
  );

  // bases waiting for the driver, and longest runs waiting for the sink
  probe_base_t     pending_bases[$];
  logic [RunW-1:0] expected_runs[$];

  // predictor state: its own copy of the target and of the diagonal counters
  logic [TargetW-1:0] target_copy = '0;
  logic [RunW-1:0]    run_len[TARGET_LEN];
  logic [RunW-1:0]    best_len = '0;

  int unsigned bases_offered  = 0;  // owned by the driver
  int unsigned bases_taken    = 0;  // owned by the monitor
  int unsigned mismatches     = 0;
  int unsigned idle_cycles    = 0;
  int unsigned hold_requests  = 0;  // bumped by the stimulus, served by the sink
  bit          steady_flow    = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    for (int k = 0; k < TARGET_LEN; k++) run_len[k] = '0;
  end

  // target base at a position, positions past the register read as code 0
  function automatic logic [BaseW-1:0] base_of(input logic [TargetW-1:0] tgt, input int pos);
    if (pos >= RegBases) return '0;
    return tgt[BaseW*pos +: BaseW];
  endfunction

  // 0 pairs with 1, 2 with 3
  function automatic bit pairs_with(input logic [BaseW-1:0] a, input logic [BaseW-1:0] b);
    return (a ^ b) == 2'b01;
  endfunction

  // idle length: mostly none or short, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (steady_flow) return 0;
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // one probe base through every diagonal counter; a last base yields the best and clears
  task automatic advance_runs(input logic [BaseW-1:0] b, input logic last);
    logic [RunW-1:0] prior;
    logic [RunW-1:0] fresh;
    // top down, so each counter still sees its neighbour's old value
    for (int k = TARGET_LEN - 1; k >= 0; k--) begin
      prior = (k == 0) ? '0 : run_len[k-1];
      fresh = '0;
      if (pairs_with(base_of(target_copy, k), b)) begin
        fresh = (prior == RunMax) ? RunMax : prior + 1'b1;
      end
      run_len[k] = fresh;
      if (fresh > best_len) best_len = fresh;
    end
    if (last) begin
      expected_runs.push_back(best_len);
      for (int k = 0; k < TARGET_LEN; k++) run_len[k] = '0;
      best_len = '0;
    end
  endtask

  // probe driver: inputs change on the falling edge
  always @(negedge clk_i) begin : probe_driver
    int unsigned gap_left;
    probe_base_t item;
    if (!rst_ni) begin
      s_valid  <= 1'b0;
      gap_left = 0;
    end else if (!s_valid || bases_taken == bases_offered) begin
      // the slot is free: the previous request went through or none was up
      if (gap_left > 0) begin
        s_valid  <= 1'b0;
        gap_left--;
      end else if (pending_bases.size() > 0) begin
        item = pending_bases.pop_front();
        s_valid <= 1'b1;
        s_data  <= TdataInW'(item.base);
        s_last  <= item.last;
        bases_offered++;
        gap_left = pick_gap();
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // result sink: random stalls plus long hold-offs on request
  always @(negedge clk_i) begin : result_sink
    int unsigned hold_left;
    int unsigned holds_served;
    int unsigned sink_gap;
    if (!rst_ni) begin
      m_ready      <= 1'b0;
      hold_left    = 0;
      holds_served = 0;
      sink_gap     = 0;
    end else begin
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = HoldCycles;
      end
      if (hold_left > 0) begin
        m_ready <= 1'b0;
        hold_left--;
      end else if (sink_gap > 0) begin
        m_ready <= 1'b0;
        sink_gap--;
      end else begin
        m_ready  <= 1'b1;
        sink_gap = pick_gap();
      end
    end
  end

  // monitor: samples both sides on the rising edge, predicts and checks
  always @(posedge clk_i) begin : monitor
    logic [RunW-1:0] want;
    bit              moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_we) target_copy = cfg_wdata;
      if (s_valid && s_ready) begin
        bases_taken++;
        moved = 1'b1;
        advance_runs(s_data[BaseW-1:0], s_last);
      end
      if (m_valid && m_ready) begin
        moved = 1'b1;
        if (expected_runs.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual longest_run %0d (tdata %h)",
                   $time, m_data[RunW-1:0], m_data);
          mismatches++;
        end else begin
          want = expected_runs.pop_front();
          // padding above the run length must stay zero as well
          if (m_data !== TdataOutW'(want)) begin
            $display("%0t: longest_run mismatch, expected %0d, actual %0d (tdata %h)",
                     $time, want, m_data[RunW-1:0], m_data);
            mismatches++;
          end
        end
      end
      // watchdog
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no request moved for %0d cycles", $time, IdleLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // queue one probe; offset >= 0 makes it complement the target from there, with some noise
  task automatic queue_probe(input logic [TargetW-1:0] tgt, input int unsigned len,
                             input int offset);
    probe_base_t item;
    for (int i = 0; i < len; i++) begin
      if (offset >= 0 && $urandom_range(9, 0) != 0) begin
        item.base = base_of(tgt, offset + i) ^ 2'b01;
      end else begin
        item.base = BaseW'($urandom_range(3, 0));
      end
      item.last = (i == len - 1);
      pending_bases.push_back(item);
    end
  endtask

  // hold the stimulus until the block has nothing left in flight
  task automatic wait_drained();
    while (pending_bases.size() > 0 || bases_offered != bases_taken ||
           expected_runs.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic load_target(input logic [TargetW-1:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    logic [TargetW-1:0] tgt;
    probe_base_t        item;
    int unsigned        queued;
    int unsigned        len;
    int unsigned        pick;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset target: every code is 0, so only base 1 pairs
    tgt = '0;
    item = '{base: 2'd1, last: 1'b1}; pending_bases.push_back(item);  // lone base, pairs
    item = '{base: 2'd0, last: 1'b1}; pending_bases.push_back(item);  // lone base, no pair
    item = '{base: 2'd3, last: 1'b1}; pending_bases.push_back(item);  // both bits differ
    item = '{base: 2'd2, last: 1'b0}; pending_bases.push_back(item);
    item = '{base: 2'd1, last: 1'b1}; pending_bases.push_back(item);
    wait_drained();

    // directed, all codes 3: a full-length complementary run spans the whole target
    tgt = '1;
    load_target(tgt);
    queue_probe(tgt, TARGET_LEN, 0);
    for (int i = 0; i < TARGET_LEN; i++) pending_bases[pending_bases.size() - 1 - i].base = 2'd2;
    wait_drained();

    // random phases, each with its own target
    for (int phase = 0; phase < Phases; phase++) begin
      case (phase)
        0:       tgt = '0;
        1:       tgt = {RegBases{2'b01}};
        2:       tgt = {RegBases{2'b10}};
        Phases - 1: tgt = '1;
        default: tgt = {8'($urandom), 32'($urandom)};
      endcase
      load_target(tgt);
      steady_flow = (phase % 3 == 1);
      // one phase with the sink held off while short probes pile up
      if (phase == 4) hold_requests++;
      queued = 0;
      while (queued < PhaseBases) begin
        pick = $urandom_range(99, 0);
        if (phase == 4)     len = $urandom_range(3, 1);
        else if (pick < 12) len = $urandom_range(40, TARGET_LEN + 1);  // longer than target
        else                len = $urandom_range(12, 1);
        if ($urandom_range(99, 0) < 70) begin
          queue_probe(tgt, len, $urandom_range(TARGET_LEN - 1, 0));
        end else begin
          queue_probe(tgt, len, -1);
        end
        queued += len;
      end
      wait_drained();
    end
    steady_flow = 1'b0;

    if (mismatches == 0 && expected_runs.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ max_complementary_run_core.f @@
hw/rtl/mcr_pkg.sv
hw/rtl/mcr_diag_array.sv
hw/rtl/max_complementary_run_core.sv
bench/testbench.sv
